// ----- sv/tgl_pkg.sv -----
// ============================================================================
// tgl_pkg: shared constants, types and helpers
// Widths of the tetrahedron global-to-local map pipeline, derived from the
// coordinate and output formats.
// ============================================================================
package tgl_pkg;

    // Input and output formats.
    localparam int COORD_BITS = 21;
    localparam int LOCAL_FRAC = 16;
    localparam int OUT_BITS   = 21;

    // Edge and offset vectors: one bit wider than a coordinate.
    localparam int DW  = COORD_BITS + 1;
    // Cross product components.
    localparam int XW  = 2 * DW + 1;
    // Cross components are split into a low unsigned part and a high signed part.
    localparam int LW  = XW - DW;
    // One term of a triple product, and the sum of three terms.
    localparam int TW  = DW + XW;
    localparam int SW  = TW + 2;
    // Scaled numerator, doubled divisor and remainder widths.
    localparam int NW  = SW + LOCAL_FRAC + 2;
    localparam int DDW = SW + 1;
    localparam int RW  = DDW + OUT_BITS;

    // Cycles from an accepted item to its result strobe.
    localparam int PIPE_LAT = 8 + OUT_BITS;

    typedef logic signed [DW-1:0] t_diff;
    typedef logic signed [XW-1:0] t_cross;
    typedef logic signed [SW-1:0] t_sum;

    // Per-item flags that travel with the divider lanes.
    typedef struct packed {
        logic       is_tet;
        logic       degen;
        logic [2:0] neg;
    } t_side;

    // Extract signed coordinate k of a packed point.
    function automatic logic signed [COORD_BITS-1:0] coord(
        input logic [3*COORD_BITS-1:0] v,
        input int                      k
    );
        coord = $signed(v[k*COORD_BITS +: COORD_BITS]);
    endfunction

endpackage

// ----- sv/tgl_cross.sv -----
// ============================================================================
// tgl_cross: edge vectors and cross products
// Stage one forms the edge and offset vectors, stage two the three cross
// products that the triple products need.
// ============================================================================
module tgl_cross (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    input  logic [3*tgl_pkg::COORD_BITS-1:0]     i_v0,
    input  logic [3*tgl_pkg::COORD_BITS-1:0]     i_v1,
    input  logic [3*tgl_pkg::COORD_BITS-1:0]     i_v2,
    input  logic [3*tgl_pkg::COORD_BITS-1:0]     i_v3,
    input  logic [3*tgl_pkg::COORD_BITS-1:0]     i_q,
    input  logic                                 i_is_tet,
    output logic                                 o_valid,
    output logic                                 o_is_tet,
    output tgl_pkg::t_diff                       o_e1  [3],
    output tgl_pkg::t_diff                       o_dq  [3],
    output tgl_pkg::t_cross                      o_c23 [3],
    output tgl_pkg::t_cross                      o_cq3 [3],
    output tgl_pkg::t_cross                      o_c2q [3]
);

    localparam int CB = tgl_pkg::COORD_BITS;
    localparam int DW = tgl_pkg::DW;

    logic           r_v1;
    logic           r_tet1;
    tgl_pkg::t_diff r_e1 [3];
    tgl_pkg::t_diff r_e2 [3];
    tgl_pkg::t_diff r_e3 [3];
    tgl_pkg::t_diff r_dq [3];

    logic            r_v2;
    logic            r_tet2;
    tgl_pkg::t_diff  r_e1b [3];
    tgl_pkg::t_diff  r_dqb [3];
    tgl_pkg::t_cross r_c23 [3];
    tgl_pkg::t_cross r_cq3 [3];
    tgl_pkg::t_cross r_c2q [3];

    // Difference of two coordinates, sign extended by one bit.
    function automatic tgl_pkg::t_diff sub_c(
        input logic signed [CB-1:0] a,
        input logic signed [CB-1:0] b
    );
        sub_c = DW'(a) - DW'(b);
    endfunction

    // One cross component: b[i]*c[j] - b[j]*c[i].
    function automatic tgl_pkg::t_cross xcomp(
        input tgl_pkg::t_diff bi,
        input tgl_pkg::t_diff cj,
        input tgl_pkg::t_diff bj,
        input tgl_pkg::t_diff ci
    );
        logic signed [2*DW-1:0] p;
        logic signed [2*DW-1:0] m;
        p = bi * cj;
        m = bj * ci;
        xcomp = tgl_pkg::XW'(p) - tgl_pkg::XW'(m);
    endfunction

    // Valid bits of both stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    // Stage one: edge vectors and query offset.
    always_ff @(posedge i_clk) begin
        r_tet1 <= i_is_tet;
        for (int k = 0; k < 3; k++) begin
            r_e1[k] <= sub_c(tgl_pkg::coord(i_v1, k), tgl_pkg::coord(i_v0, k));
            r_e2[k] <= sub_c(tgl_pkg::coord(i_v2, k), tgl_pkg::coord(i_v0, k));
            r_e3[k] <= sub_c(tgl_pkg::coord(i_v3, k), tgl_pkg::coord(i_v0, k));
            r_dq[k] <= sub_c(tgl_pkg::coord(i_q,  k), tgl_pkg::coord(i_v0, k));
        end
    end

    // Stage two: the cross products e2 x e3, dq x e3 and e2 x dq.
    always_ff @(posedge i_clk) begin
        r_tet2 <= r_tet1;
        for (int k = 0; k < 3; k++) begin
            r_e1b[k] <= r_e1[k];
            r_dqb[k] <= r_dq[k];
            r_c23[k] <= xcomp(r_e2[(k+1)%3], r_e3[(k+2)%3], r_e2[(k+2)%3], r_e3[(k+1)%3]);
            r_cq3[k] <= xcomp(r_dq[(k+1)%3], r_e3[(k+2)%3], r_dq[(k+2)%3], r_e3[(k+1)%3]);
            r_c2q[k] <= xcomp(r_e2[(k+1)%3], r_dq[(k+2)%3], r_e2[(k+2)%3], r_dq[(k+1)%3]);
        end
    end

    assign o_valid  = r_v2;
    assign o_is_tet = r_tet2;
    assign o_e1     = r_e1b;
    assign o_dq     = r_dqb;
    assign o_c23    = r_c23;
    assign o_cq3    = r_cq3;
    assign o_c2q    = r_c2q;

endmodule

// ----- sv/tgl_triple.sv -----
// ============================================================================
// tgl_triple: triple products
// Forms the determinant and the three Cramer numerators over three stages:
// split partial products, term assembly, and the three-term sum.
// ============================================================================
module tgl_triple (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic            i_is_tet,
    input  tgl_pkg::t_diff  i_e1  [3],
    input  tgl_pkg::t_diff  i_dq  [3],
    input  tgl_pkg::t_cross i_c23 [3],
    input  tgl_pkg::t_cross i_cq3 [3],
    input  tgl_pkg::t_cross i_c2q [3],
    output logic            o_valid,
    output logic            o_is_tet,
    output tgl_pkg::t_sum   o_det,
    output tgl_pkg::t_sum   o_num [3]
);

    localparam int DW = tgl_pkg::DW;
    localparam int XW = tgl_pkg::XW;
    localparam int LW = tgl_pkg::LW;
    localparam int TW = tgl_pkg::TW;
    localparam int SW = tgl_pkg::SW;

    // Products: index 0 is det, 1..3 the numerators.
    tgl_pkg::t_diff  a_op [4][3];
    tgl_pkg::t_cross x_op [4][3];

    logic                   r_v3, r_v4, r_v5;
    logic                   r_tet3, r_tet4, r_tet5;
    logic signed [2*DW-1:0] r_ph [4][3];
    logic signed [2*DW+1:0] r_pl [4][3];
    logic signed [TW-1:0]   r_tm [4][3];
    tgl_pkg::t_sum          r_sum [4];

    // Operand routing for the four triple products.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            a_op[0][k] = i_e1[k];  x_op[0][k] = i_c23[k];
            a_op[1][k] = i_dq[k];  x_op[1][k] = i_c23[k];
            a_op[2][k] = i_e1[k];  x_op[2][k] = i_cq3[k];
            a_op[3][k] = i_e1[k];  x_op[3][k] = i_c2q[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            r_v3 <= i_valid;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    // Stage three: each product is split into high and low halves of the cross term.
    always_ff @(posedge i_clk) begin
        r_tet3 <= i_is_tet;
        for (int t = 0; t < 4; t++) begin
            for (int k = 0; k < 3; k++) begin
                r_ph[t][k] <= a_op[t][k] * $signed(x_op[t][k][XW-1:LW]);
                r_pl[t][k] <= a_op[t][k] * $signed({1'b0, x_op[t][k][LW-1:0]});
            end
        end
    end

    // Stage four: reassemble each full-width term.
    always_ff @(posedge i_clk) begin
        r_tet4 <= r_tet3;
        for (int t = 0; t < 4; t++) begin
            for (int k = 0; k < 3; k++) begin
                r_tm[t][k] <= (TW'(r_ph[t][k]) <<< LW) + TW'(r_pl[t][k]);
            end
        end
    end

    // Stage five: sum the three terms of each triple product.
    always_ff @(posedge i_clk) begin
        r_tet5 <= r_tet4;
        for (int t = 0; t < 4; t++) begin
            r_sum[t] <= SW'(r_tm[t][0]) + SW'(r_tm[t][1]) + SW'(r_tm[t][2]);
        end
    end

    assign o_valid  = r_v5;
    assign o_is_tet = r_tet5;
    assign o_det    = r_sum[0];
    assign o_num[0] = r_sum[1];
    assign o_num[1] = r_sum[2];
    assign o_num[2] = r_sum[3];

endmodule

// ----- sv/tgl_div.sv -----
// ============================================================================
// tgl_div: three-lane pipelined rounding divider
// Computes round(num * 2^LOCAL_FRAC / det) magnitudes, one quotient bit per
// stage, with an overflow check before the first bit.
// ============================================================================
module tgl_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic                          i_is_tet,
    input  tgl_pkg::t_sum                 i_det,
    input  tgl_pkg::t_sum                 i_num [3],
    output logic                          o_valid,
    output tgl_pkg::t_side                o_side,
    output logic [tgl_pkg::OUT_BITS-1:0]  o_quo [3],
    output logic [2:0]                    o_ovf
);

    localparam int SW  = tgl_pkg::SW;
    localparam int NW  = tgl_pkg::NW;
    localparam int DDW = tgl_pkg::DDW;
    localparam int RW  = tgl_pkg::RW;
    localparam int OB  = tgl_pkg::OUT_BITS;
    localparam int LF  = tgl_pkg::LOCAL_FRAC;

    // Preparation stage.
    logic           r_pv;
    tgl_pkg::t_side r_pside;
    logic [NW-1:0]  r_pn [3];
    logic [DDW-1:0] r_pd2;

    // Bit stages: index 0 holds the item after the overflow check.
    logic           r_vld  [OB+1];
    tgl_pkg::t_side r_side [OB+1];
    logic [DDW-1:0] r_d2   [OB+1];
    logic [RW-1:0]  r_rem  [OB+1][3];
    logic [OB-1:0]  r_quo  [OB+1][3];
    logic [2:0]     r_ovf  [OB+1];

    logic [SW-1:0]  mag_d;
    logic [SW-1:0]  mag_n [3];
    tgl_pkg::t_side n_pside;

    // Magnitudes and signs of the operands.
    always_comb begin
        mag_d = i_det[SW-1] ? SW'(-i_det) : SW'(i_det);
        n_pside.is_tet = i_is_tet;
        n_pside.degen  = (i_det == '0);
        for (int l = 0; l < 3; l++) begin
            mag_n[l]       = i_num[l][SW-1] ? SW'(-i_num[l]) : SW'(i_num[l]);
            n_pside.neg[l] = i_num[l][SW-1] ^ i_det[SW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
            for (int s = 0; s <= OB; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else begin
            r_pv     <= i_valid;
            r_vld[0] <= r_pv;
            for (int s = 0; s < OB; s++) begin
                r_vld[s+1] <= r_vld[s];
            end
        end
    end

    // Preparation: scaled numerator with the rounding half added, doubled divisor.
    always_ff @(posedge i_clk) begin
        r_pside <= n_pside;
        r_pd2   <= {mag_d, 1'b0};
        for (int l = 0; l < 3; l++) begin
            r_pn[l] <= (NW'(mag_n[l]) << (LF + 1)) + NW'(mag_d);
        end
    end

    // Overflow check: a quotient of 2^OUT_BITS or more is flagged for clamping.
    always_ff @(posedge i_clk) begin
        r_side[0] <= r_pside;
        r_d2[0]   <= r_pd2;
        for (int l = 0; l < 3; l++) begin
            r_rem[0][l] <= RW'(r_pn[l]);
            r_quo[0][l] <= '0;
            r_ovf[0][l] <= (RW'(r_pn[l]) >= (RW'(r_pd2) << OB));
        end
    end

    // Restoring division, one quotient bit per stage, most significant first.
    for (genvar s = 0; s < OB; s++) begin : g_bit
        localparam int B = OB - 1 - s;
        always_ff @(posedge i_clk) begin
            r_side[s+1] <= r_side[s];
            r_d2[s+1]   <= r_d2[s];
            r_ovf[s+1]  <= r_ovf[s];
            for (int l = 0; l < 3; l++) begin
                if (r_rem[s][l] >= (RW'(r_d2[s]) << B)) begin
                    r_rem[s+1][l] <= r_rem[s][l] - (RW'(r_d2[s]) << B);
                    r_quo[s+1][l] <= r_quo[s][l] | (OB'(1) << B);
                end else begin
                    r_rem[s+1][l] <= r_rem[s][l];
                    r_quo[s+1][l] <= r_quo[s][l];
                end
            end
        end
    end

    assign o_valid = r_vld[OB];
    assign o_side  = r_side[OB];
    assign o_quo   = r_quo[OB];
    assign o_ovf   = r_ovf[OB];

endmodule

// ----- sv/tet_global_to_local_map_top.sv -----
// ============================================================================
// tet_global_to_local_map_top: tetrahedron global-to-local coordinate map
// Maps a global point into the parametric coordinates of a linear tetrahedron
// through exact triple products and a pipelined rounding divider.
// ============================================================================
// An item is taken at every clock edge with start high; busy never rises, so
// a new item may be issued in every cycle. Each result is held on o_valid for
// one cycle only; the receiver must take it then. Items pass through seven
// stages of differences, cross products, triple products and divider setup,
// then the quotient divider, which resolves one bit per stage for 21 stages,
// and finally the output register. Results come out in the order the items
// went in.
module tet_global_to_local_map_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [3*tgl_pkg::COORD_BITS-1:0]     i_vertex_zero,
    input  logic [3*tgl_pkg::COORD_BITS-1:0]     i_vertex_one,
    input  logic [3*tgl_pkg::COORD_BITS-1:0]     i_vertex_two,
    input  logic [3*tgl_pkg::COORD_BITS-1:0]     i_vertex_three,
    input  logic [3*tgl_pkg::COORD_BITS-1:0]     i_query_point,
    input  logic                                 i_is_tetrahedron,
    output logic                                 o_valid,
    output logic [3*tgl_pkg::OUT_BITS-1:0]       o_local_coords,
    output logic                                 o_degenerate,
    output logic                                 o_saturated
);

    localparam int OB = tgl_pkg::OUT_BITS;

    logic            x_valid, x_tet;
    tgl_pkg::t_diff  x_e1  [3];
    tgl_pkg::t_diff  x_dq  [3];
    tgl_pkg::t_cross x_c23 [3];
    tgl_pkg::t_cross x_cq3 [3];
    tgl_pkg::t_cross x_c2q [3];

    logic            t_valid, t_tet;
    tgl_pkg::t_sum   t_det;
    tgl_pkg::t_sum   t_num [3];

    logic            d_valid;
    tgl_pkg::t_side  d_side;
    logic [OB-1:0]   d_quo [3];
    logic [2:0]      d_ovf;

    logic                 r_valid;
    logic [3*OB-1:0]      r_coords;
    logic                 r_degen;
    logic                 r_sat;
    logic [3*OB-1:0]      n_coords;
    logic                 n_degen;
    logic                 n_sat;

    assign busy = 1'b0;

    tgl_cross u_cross (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (start),
        .i_v0     (i_vertex_zero),
        .i_v1     (i_vertex_one),
        .i_v2     (i_vertex_two),
        .i_v3     (i_vertex_three),
        .i_q      (i_query_point),
        .i_is_tet (i_is_tetrahedron),
        .o_valid  (x_valid),
        .o_is_tet (x_tet),
        .o_e1     (x_e1),
        .o_dq     (x_dq),
        .o_c23    (x_c23),
        .o_cq3    (x_cq3),
        .o_c2q    (x_c2q)
    );

    tgl_triple u_triple (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (x_valid),
        .i_is_tet (x_tet),
        .i_e1     (x_e1),
        .i_dq     (x_dq),
        .i_c23    (x_c23),
        .i_cq3    (x_cq3),
        .i_c2q    (x_c2q),
        .o_valid  (t_valid),
        .o_is_tet (t_tet),
        .o_det    (t_det),
        .o_num    (t_num)
    );

    tgl_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (t_valid),
        .i_is_tet (t_tet),
        .i_det    (t_det),
        .i_num    (t_num),
        .o_valid  (d_valid),
        .o_side   (d_side),
        .o_quo    (d_quo),
        .o_ovf    (d_ovf)
    );

    // Clamp, apply the sign, and force zeros for degenerate or non-tet items.
    always_comb begin
        logic [OB-1:0] lim;
        logic [OB-1:0] m;
        logic          sat;
        n_coords = '0;
        n_sat    = 1'b0;
        for (int l = 0; l < 3; l++) begin
            lim = d_side.neg[l] ? (OB'(1) << (OB - 1)) : ((OB'(1) << (OB - 1)) - OB'(1));
            sat = d_ovf[l] || (d_quo[l] > lim);
            m   = sat ? lim : d_quo[l];
            n_coords[l*OB +: OB] = d_side.neg[l] ? (OB'(0) - m) : m;
            n_sat = n_sat | sat;
        end
        n_degen = d_side.is_tet & d_side.degen;
        if (!d_side.is_tet || d_side.degen) begin
            n_coords = '0;
            n_sat    = 1'b0;
        end
    end

    // Output register and result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_coords <= n_coords;
        r_degen  <= n_degen;
        r_sat    <= n_sat;
    end

    assign o_valid        = r_valid;
    assign o_local_coords = r_coords;
    assign o_degenerate   = r_degen;
    assign o_saturated    = r_sat;

    // Every item produces its result after the fixed pipeline latency.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##(tgl_pkg::PIPE_LAT) o_valid)
        else $error("item did not produce a result after the pipeline latency");

    // No result appears without an item issued one latency earlier.
    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, tgl_pkg::PIPE_LAT))
        else $error("result strobe without a matching item");

    // A degenerate element gives zero coordinates and no saturation.
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_degenerate) |-> (o_local_coords == '0 && !o_saturated))
        else $error("degenerate result is not zero");

endmodule
